// ===== src/tojq_pkg.sv =====
package tojq_pkg;

  // queue depth and derived widths
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned DLY_W    = 32;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STAT_W   = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT     = 2'd0,
    ACT_POP        = 2'd1,
    ACT_PUSH_FRONT = 2'd2,
    ACT_CLEAR      = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // whole-row operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_SHL   = 2'd1,
    OP_SHR   = 2'd2
  } shift_op_e;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [DLY_W-1:0] dly;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  // job traveling down the row during a sorted insert
  typedef struct packed {
    logic   vld;
    logic   shift;
    entry_t ent;
  } tok_t;

  typedef struct packed {
    shift_op_e        op;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

endpackage

// ===== src/tojq_if.sv =====
interface tojq_req_if;
  import tojq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic [KEY_W-1:0]        sched_time;
  logic signed [DLY_W-1:0] delay_value;
  logic [TAG_W-1:0]        job_tag;

  modport source (output valid, action, sched_time, delay_value, job_tag, input ready);
  modport sink   (input valid, action, sched_time, delay_value, job_tag, output ready);
endinterface

interface tojq_rsp_if;
  import tojq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    popped_valid;
  logic [KEY_W-1:0]        out_sched_time;
  logic signed [DLY_W-1:0] out_delay;
  logic [TAG_W-1:0]        out_tag;
  logic [COUNT_W-1:0]      entry_count;
  logic [STAT_W-1:0]       status;

  modport source (output valid, popped_valid, out_sched_time, out_delay, out_tag,
                  entry_count, status, input ready);
  modport sink   (input valid, popped_valid, out_sched_time, out_delay, out_tag,
                  entry_count, status, output ready);
endinterface

// ===== src/time_ordered_job_queue.sv =====
// channel  dir  modport      contents
// req_i    in   sink         action, sched_time, delay_value, job_tag
// rsp_o    out  source       popped_valid, out_sched_time, out_delay, out_tag,
//                            entry_count, status
//
// pop, push front, clear and a rejected insert finish in the cycle they are taken
// a sorted insert into a non-empty queue walks the job down the cell row one cell per cycle
// and no new request is taken until it has settled
// the result sits in an output register; a new request is taken while it is being drained
// reset empties the queue at once; cell contents are left as they were
module time_ordered_job_queue import tojq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  tojq_req_if.sink   req_i,
  tojq_rsp_if.source rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] walk_q, walk_d;
  logic             full, empty, accept;
  cell_ctrl_t       ctrl;
  tok_t             inj_tok;
  entry_t           in_ent;
  entry_t           data_w [CAPACITY];
  tok_t             tok_w  [CAPACITY];

  logic             out_vld_q;
  logic             pop_vld_q, pop_vld_d;
  entry_t           pop_ent_q, pop_ent_d;
  logic [CNT_W-1:0] res_cnt_q, res_cnt_d;
  status_e          stat_q, stat_d;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  assign req_i.ready = (state_q == ST_IDLE) && (!out_vld_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign in_ent.key = req_i.sched_time;
  assign in_ent.dly = req_i.delay_value;
  assign in_ent.tag = req_i.job_tag;

  // request decode and insert sequencing
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    walk_d        = walk_q;
    ctrl.op       = OP_HOLD;
    ctrl.count    = count_q;
    inj_tok.vld   = 1'b0;
    inj_tok.shift = 1'b0;
    inj_tok.ent   = in_ent;
    pop_vld_d     = pop_vld_q;
    pop_ent_d     = pop_ent_q;
    res_cnt_d     = res_cnt_q;
    stat_d        = stat_q;
    unique case (state_q)
      ST_WALK: begin
        if ({{(CNT_W - IDX_W){1'b0}}, walk_q} == count_q) begin
          count_d = count_q + CNT_W'(1);
          state_d = ST_IDLE;
        end else begin
          walk_d = walk_q + IDX_W'(1);
        end
      end
      default: begin
        if (accept) begin
          pop_vld_d = 1'b0;
          pop_ent_d = '0;
          stat_d    = STAT_OK;
          res_cnt_d = count_q;
          unique case (action_e'(req_i.action))
            ACT_INSERT: begin
              if (full) begin
                stat_d = STAT_FULL;
              end else begin
                inj_tok.vld = 1'b1;
                res_cnt_d   = count_q + CNT_W'(1);
                if (empty) begin
                  count_d = CNT_W'(1);
                end else begin
                  state_d = ST_WALK;
                  walk_d  = IDX_W'(1);
                end
              end
            end
            ACT_POP: begin
              if (empty) begin
                stat_d = STAT_EMPTY;
              end else begin
                ctrl.op   = OP_SHL;
                pop_vld_d = 1'b1;
                pop_ent_d = data_w[0];
                count_d   = count_q - CNT_W'(1);
                res_cnt_d = count_q - CNT_W'(1);
              end
            end
            ACT_PUSH_FRONT: begin
              if (full) begin
                stat_d = STAT_FULL;
              end else begin
                ctrl.op   = OP_SHR;
                count_d   = count_q + CNT_W'(1);
                res_cnt_d = count_q + CNT_W'(1);
              end
            end
            ACT_CLEAR: begin
              count_d   = '0;
              res_cnt_d = '0;
            end
            default: begin
              stat_d = STAT_OK;
            end
          endcase
        end
      end
    endcase
  end

  // row of storage cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t left_w, right_w;
    tok_t   tin_w;

    if (g == 0) begin : g_head
      assign left_w = in_ent;
      assign tin_w  = inj_tok;
    end else begin : g_body
      assign left_w = data_w[g-1];
      assign tin_w  = tok_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = data_w[g];
    end else begin : g_inner
      assign right_w = data_w[g+1];
    end

    tojq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(g)),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .tok_i   (tin_w),
      .data_o  (data_w[g]),
      .tok_o   (tok_w[g])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      walk_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      walk_q  <= walk_d;
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    pop_vld_q <= pop_vld_d;
    pop_ent_q <= pop_ent_d;
    res_cnt_q <= res_cnt_d;
    stat_q    <= stat_d;
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.popped_valid   = pop_vld_q;
  assign rsp_o.out_sched_time = pop_ent_q.key;
  assign rsp_o.out_delay      = pop_ent_q.dly;
  assign rsp_o.out_tag        = pop_ent_q.tag;
  assign rsp_o.entry_count    = COUNT_W'(res_cnt_q);
  assign rsp_o.status         = stat_q;

endmodule

// ===== src/tojq_cell.sv =====
module tojq_cell import tojq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  cell_ctrl_t       ctrl_i,
  input  entry_t           left_i,
  input  entry_t           right_i,
  input  tok_t             tok_i,
  output entry_t           data_o,
  output tok_t             tok_o
);

  entry_t data_q, data_d;
  tok_t   tok_q, tok_d;
  logic   at_end;

  // this cell is the first free slot
  assign at_end = ({{(CNT_W - IDX_W){1'b0}}, idx_i} == ctrl_i.count);

  // shift, absorb or pass the traveling job
  always_comb begin
    data_d = data_q;
    tok_d  = '0;
    unique case (ctrl_i.op)
      OP_SHL: begin
        data_d = right_i;
      end
      OP_SHR: begin
        data_d = left_i;
      end
      default: begin
        if (tok_i.vld) begin
          if (at_end) begin
            data_d = tok_i.ent;
          end else if (tok_i.shift || (tok_i.ent.key < data_q.key)) begin
            data_d    = tok_i.ent;
            tok_d.vld   = 1'b1;
            tok_d.shift = 1'b1;
            tok_d.ent   = data_q;
          end else begin
            tok_d = tok_i;
          end
        end
      end
    endcase
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // token toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign data_o = data_q;
  assign tok_o  = tok_q;

endmodule

// ===== test/time_ordered_job_queue_tb.sv =====
module time_ordered_job_queue_tb;
  import tojq_pkg::*;

  localparam int unsigned STALL_MAX  = 17;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned HOLD_AT    = 200;
  localparam int unsigned RAND_JOBS  = 1000;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned REPORT_MAX = 200;

  // one reply as the block should return it
  typedef struct packed {
    logic                    popped;
    logic [KEY_W-1:0]        key;
    logic signed [DLY_W-1:0] dly;
    logic [TAG_W-1:0]        tag;
    logic [COUNT_W-1:0]      count;
    status_e                 status;
  } reply_t;

  // one directed row, repeated rep times with the tag stepping up
  typedef struct {
    action_e              act;
    logic [KEY_W-1:0]     key;
    logic [DLY_W-1:0]     dly;
    logic [TAG_W-1:0]     tag;
    int unsigned          rep;
    bit                   typed;
    logic [COUNT_W-1:0]   count;
    status_e              status;
  } plan_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tojq_req_if req_if ();
  tojq_rsp_if rsp_if ();

  time_ordered_job_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // predictor state: jobs in queue order and how many are held
  entry_t      model_jobs [CAPACITY+1];
  int unsigned model_count;

  reply_t      due_replies [$];
  int unsigned fault_count   = 0;
  int unsigned replies_taken = 0;
  int unsigned idle_cycles   = 0;
  bit          sender_idles;
  bit          receiver_idles;

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // open a slot at pos by moving later jobs back one place
  function automatic void model_place(int unsigned pos, entry_t job);
    int unsigned i;
    for (i = model_count; i > pos; i--) model_jobs[i] = model_jobs[i-1];
    model_jobs[pos] = job;
    model_count++;
  endfunction

  // apply one request to the predictor and return the reply it causes
  function automatic reply_t apply_action(action_e act, entry_t job);
    reply_t      r;
    int unsigned pos;
    int unsigned i;
    r = '0;
    r.status = STAT_OK;
    case (act)
      ACT_INSERT: begin
        if (model_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          // stop at the first strictly later time, ties stay in arrival order
          pos = model_count;
          for (i = 0; i < model_count; i++) begin
            if (job.key < model_jobs[i].key) begin
              pos = i;
              break;
            end
          end
          model_place(pos, job);
        end
      end
      ACT_POP: begin
        if (model_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.popped = 1'b1;
          r.key    = model_jobs[0].key;
          r.dly    = model_jobs[0].dly;
          r.tag    = model_jobs[0].tag;
          for (i = 1; i < model_count; i++) model_jobs[i-1] = model_jobs[i];
          model_count--;
        end
      end
      ACT_PUSH_FRONT: begin
        if (model_count >= CAPACITY) r.status = STAT_FULL;
        else model_place(0, job);
      end
      default: begin
        model_count = 0;
      end
    endcase
    r.count = model_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t row(action_e act, logic [KEY_W-1:0] key,
                                    logic [DLY_W-1:0] dly, logic [TAG_W-1:0] tag,
                                    int unsigned rep, bit typed,
                                    logic [COUNT_W-1:0] count, status_e status);
    plan_row_t p;
    p.act    = act;
    p.key    = key;
    p.dly    = dly;
    p.tag    = tag;
    p.rep    = rep;
    p.typed  = typed;
    p.count  = count;
    p.status = status;
    return p;
  endfunction

  // offer one request, wait for it to be taken, then record its reply
  task automatic send_job(action_e act, logic [KEY_W-1:0] key, logic [DLY_W-1:0] dly,
                          logic [TAG_W-1:0] tag, bit typed,
                          logic [COUNT_W-1:0] count, status_e status);
    int unsigned gap;
    entry_t      job;
    reply_t      r;
    if ($urandom_range(0, 39) == 0) sender_idles = !sender_idles;
    gap = sender_idles ? $urandom_range(0, STALL_MAX) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.action      <= act;
    req_if.sched_time  <= key;
    req_if.delay_value <= dly;
    req_if.job_tag     <= tag;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    job.key = key;
    job.dly = dly;
    job.tag = tag;
    r = apply_action(act, job);
    // rows whose reply is plain from the table override the predictor
    if (typed) begin
      r        = '0;
      r.count  = count;
      r.status = status;
    end
    due_replies.push_back(r);
  endtask

  function automatic void check_field(string name, logic [KEY_W-1:0] want,
                                      logic [KEY_W-1:0] got);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // compare each reply taken with the oldest one due
  always @(posedge clk_i) begin : check_replies
    reply_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (due_replies.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("%0t: unexpected reply, expected none, actual count %h status %h",
                   $time, rsp_if.entry_count, rsp_if.status);
      end else begin
        want = due_replies.pop_front();
        check_field("popped_valid", KEY_W'(want.popped), KEY_W'(rsp_if.popped_valid));
        check_field("out_sched_time", want.key, rsp_if.out_sched_time);
        check_field("out_delay", want.dly, rsp_if.out_delay);
        check_field("out_tag", KEY_W'(want.tag), KEY_W'(rsp_if.out_tag));
        check_field("entry_count", KEY_W'(want.count), KEY_W'(rsp_if.entry_count));
        check_field("status", KEY_W'(want.status), KEY_W'(rsp_if.status));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("time_ordered_job_queue regression: fail");
      $finish;
    end
  end

  // reply side: random stalls, one long hold-off to back up the queue
  initial begin : drain_replies
    int unsigned gap;
    receiver_idles = 1'b1;
    rsp_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) receiver_idles = !receiver_idles;
      gap = receiver_idles ? $urandom_range(0, STALL_MAX) : 0;
      if (replies_taken == HOLD_AT) gap = HOLD_LEN;
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
      replies_taken++;
    end
  end

  // reset, directed rows, random requests, then the verdict
  initial begin : run_jobs
    plan_row_t   plan [$];
    int unsigned n;
    int unsigned k;
    bit          fill_mode;
    int unsigned pick;
    action_e     act;
    logic [KEY_W-1:0] key;

    model_count   = 0;
    sender_idles  = 1'b1;
    fill_mode     = 1'b1;
    req_if.valid       <= 1'b0;
    req_if.action      <= ACT_CLEAR;
    req_if.sched_time  <= '0;
    req_if.delay_value <= '0;
    req_if.job_tag     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pop and clear right after reset
    plan.push_back(row(ACT_POP, 32'h0, 32'h0, 16'h0, 1, 1, 0, STAT_EMPTY));
    plan.push_back(row(ACT_CLEAR, 32'h0, 32'h0, 16'h0, 1, 1, 0, STAT_OK));
    // field extremes and a tie on equal times
    plan.push_back(row(ACT_INSERT, 32'hffff_ffff, 32'h7fff_ffff, 16'hffff, 1, 1, 1, STAT_OK));
    plan.push_back(row(ACT_INSERT, 32'h0, 32'h8000_0000, 16'h0, 1, 1, 2, STAT_OK));
    plan.push_back(row(ACT_INSERT, 32'h8000_0000, 32'hffff_ffff, 16'h1, 1, 1, 3, STAT_OK));
    plan.push_back(row(ACT_INSERT, 32'h8000_0000, 32'h0, 16'h2, 1, 1, 4, STAT_OK));
    // late job pushed to the head breaks the order, next insert lands before it
    plan.push_back(row(ACT_PUSH_FRONT, 32'hffff_ffff, 32'h1, 16'h3, 1, 1, 5, STAT_OK));
    plan.push_back(row(ACT_INSERT, 32'h5, 32'h2, 16'h4, 1, 0, 0, STAT_OK));
    plan.push_back(row(ACT_POP, 32'h0, 32'h0, 16'h0, 6, 0, 0, STAT_OK));
    plan.push_back(row(ACT_POP, 32'h0, 32'h0, 16'h0, 1, 1, 0, STAT_EMPTY));
    // clear of a queue that holds a job
    plan.push_back(row(ACT_PUSH_FRONT, 32'h0, 32'h5555_aaaa, 16'h5, 1, 1, 1, STAT_OK));
    plan.push_back(row(ACT_CLEAR, 32'h0, 32'h0, 16'h0, 1, 1, 0, STAT_OK));
    // fill with equal times, then both kinds of write into a full queue
    plan.push_back(row(ACT_INSERT, 32'h1234, 32'haaaa_5555, 16'h100, CAPACITY, 0, 0, STAT_OK));
    plan.push_back(row(ACT_INSERT, 32'h0, 32'h0, 16'h7, 1, 1, COUNT_W'(CAPACITY),
                       STAT_FULL));
    plan.push_back(row(ACT_PUSH_FRONT, 32'h0, 32'h0, 16'h8, 1, 1, COUNT_W'(CAPACITY),
                       STAT_FULL));
    plan.push_back(row(ACT_POP, 32'h0, 32'h0, 16'h0, 3, 0, 0, STAT_OK));
    plan.push_back(row(ACT_INSERT, 32'h1234, 32'h1, 16'h200, 3, 0, 0, STAT_OK));
    plan.push_back(row(ACT_POP, 32'h0, 32'h0, 16'h0, CAPACITY, 0, 0, STAT_OK));
    plan.push_back(row(ACT_POP, 32'h0, 32'h0, 16'h0, 1, 1, 0, STAT_EMPTY));
    plan.push_back(row(ACT_INSERT, 32'hffff_ffff, 32'h0, 16'h9, 1, 1, 1, STAT_OK));
    plan.push_back(row(ACT_CLEAR, 32'h0, 32'h0, 16'h0, 1, 1, 0, STAT_OK));

    foreach (plan[r]) begin
      for (k = 0; k < plan[r].rep; k++)
        send_job(plan[r].act, plan[r].key, plan[r].dly, plan[r].tag + k[TAG_W-1:0],
                 plan[r].typed, plan[r].count, plan[r].status);
    end

    // random part: fill-heavy and drain-heavy stretches to reach full and empty
    for (n = 0; n < RAND_JOBS; n++) begin
      if ($urandom_range(0, 29) == 0) fill_mode = !fill_mode;
      pick = $urandom_range(0, 99);
      if (pick < 1) act = ACT_CLEAR;
      else if (pick < 11) act = ACT_PUSH_FRONT;
      else if (pick < (fill_mode ? 78 : 38)) act = ACT_INSERT;
      else act = ACT_POP;
      // narrow key ranges make ties common
      case ($urandom_range(0, 5))
        0, 1:    key = $urandom_range(0, 7);
        2:       key = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
        3:       key = 32'hffff_fff8 + $urandom_range(0, 7);
        default: key = $urandom;
      endcase
      send_job(act, key, $urandom, TAG_W'($urandom_range(0, 65535)), 0, 0, STAT_OK);
    end
    req_if.valid <= 1'b0;

    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (CAPACITY + 4) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("time_ordered_job_queue regression: pass");
    end else begin
      $display("time_ordered_job_queue regression: fail");
    end
    $finish;
  end

endmodule
